// ===== rtl/fsnf_pkg.sv =====
package fsnf_pkg;

    localparam int unsigned PK_LEN      = 11;
    localparam int unsigned PK_NAME_LEN = 8;
    localparam int unsigned PK_EXT_LEN  = 3;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_LOW_A = 8'd97;
    localparam logic [7:0] CH_LOW_Z = 8'd122;
    localparam logic [7:0] CASE_GAP = 8'd32;

    localparam logic [3:0] IDX_LAST = 4'(PK_LEN - 1);

    typedef logic [7:0] t_store [PK_LEN];

    typedef enum logic [1:0] {
        PH_NAME = 2'd0,
        PH_EXT  = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            r = c - CASE_GAP;
        end
        return r;
    endfunction

endpackage

// ===== rtl/fat_short_name_formatter_top.sv =====
// Packs a file name, streamed in one character per beat, into the 11-byte
// 8.3 short-name form: eight name bytes, then three extension bytes, all
// space padded and with a to z turned to upper case. A NUL character or the
// beat marked by tlast ends the name; the tlast beat's own character is
// taken first, and then the 11 bytes leave on the master side in order,
// byte 0 first, with tlast on byte 10. Input beats are taken one per cycle
// while s_tready is high: the character goes straight into a working store,
// and on a tlast beat the finished store is copied into an output shift
// register, or into a single waiting buffer when that register is still
// emitting. s_tready drops only while a finished name is waiting in that
// buffer, so the next name can be received while the previous one is still
// leaving on the master side.
module fat_short_name_formatter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave side: tdata = name_char[7:0]; tlast = final_char.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    // Master side: tdata = packed_byte[7:0], byte_index[11:8], zeros[15:12];
    // tlast = last_byte.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    output logic        o_m_tlast
);

    // Working store for the name being received.
    fsnf_pkg::t_store  r_store;
    logic [3:0]        r_pos;
    logic [1:0]        r_ext;
    fsnf_pkg::t_phase  r_phase;

    // Output shift register and its waiting buffer.
    fsnf_pkg::t_store  r_emit;
    logic [3:0]        r_idx;
    logic              r_emit_valid;
    fsnf_pkg::t_store  r_pend;
    logic              r_pend_valid;

    fsnf_pkg::t_store  taken_store;
    logic [3:0]        taken_pos;
    logic [1:0]        taken_ext;
    fsnf_pkg::t_phase  taken_phase;
    logic [7:0]        up_char;

    logic              in_beat;
    logic              fin_beat;
    logic              out_beat;
    logic              emit_done;

    assign in_beat   = i_s_tvalid && o_s_tready;
    assign fin_beat  = in_beat && i_s_tlast;
    assign out_beat  = r_emit_valid && i_m_tready;
    assign emit_done = out_beat && (r_idx == fsnf_pkg::IDX_LAST);

    // Input is taken only while the waiting buffer is empty, so a finished
    // name always has a free slot to go to.
    assign o_s_tready = !r_pend_valid;

    assign up_char = fsnf_pkg::to_upper(i_s_tdata);

    // One character applied to the working store.
    always_comb begin
        taken_store = r_store;
        taken_pos   = r_pos;
        taken_ext   = r_ext;
        taken_phase = r_phase;
        unique case (r_phase)
            fsnf_pkg::PH_NAME: begin
                if (i_s_tdata == fsnf_pkg::CH_NUL) begin
                    taken_phase = fsnf_pkg::PH_DONE;
                end else if (i_s_tdata == fsnf_pkg::CH_DOT) begin
                    taken_phase = fsnf_pkg::PH_EXT;
                    taken_ext   = 2'd0;
                end else if (r_pos < 4'(fsnf_pkg::PK_NAME_LEN)) begin
                    taken_store[r_pos] = up_char;
                    taken_pos          = r_pos + 4'd1;
                end else begin
                    // Ninth character is no dot: it opens the extension.
                    taken_store[4'(fsnf_pkg::PK_NAME_LEN)] = up_char;
                    taken_ext   = 2'd1;
                    taken_phase = fsnf_pkg::PH_EXT;
                end
            end
            fsnf_pkg::PH_EXT: begin
                if (i_s_tdata == fsnf_pkg::CH_NUL) begin
                    taken_phase = fsnf_pkg::PH_DONE;
                end else if (r_ext < 2'(fsnf_pkg::PK_EXT_LEN)) begin
                    taken_store[4'(fsnf_pkg::PK_NAME_LEN) + {2'b00, r_ext}] = up_char;
                    taken_ext = r_ext + 2'd1;
                    if (r_ext + 2'd1 >= 2'(fsnf_pkg::PK_EXT_LEN)) begin
                        taken_phase = fsnf_pkg::PH_DONE;
                    end
                end else begin
                    taken_phase = fsnf_pkg::PH_DONE;
                end
            end
            default: begin
                // Ended: characters are ignored until the last beat.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < fsnf_pkg::PK_LEN; k++) begin
                r_store[k] <= fsnf_pkg::CH_SPACE;
            end
            r_pos   <= 4'd0;
            r_ext   <= 2'd0;
            r_phase <= fsnf_pkg::PH_NAME;
        end else if (in_beat) begin
            if (i_s_tlast) begin
                for (int k = 0; k < fsnf_pkg::PK_LEN; k++) begin
                    r_store[k] <= fsnf_pkg::CH_SPACE;
                end
                r_pos   <= 4'd0;
                r_ext   <= 2'd0;
                r_phase <= fsnf_pkg::PH_NAME;
            end else begin
                r_store <= taken_store;
                r_pos   <= taken_pos;
                r_ext   <= taken_ext;
                r_phase <= taken_phase;
            end
        end
    end

    // Emitter: load from the waiting buffer first, else from a finished name
    // arriving now; otherwise shift one byte out per beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_valid <= 1'b0;
            r_pend_valid <= 1'b0;
            r_idx        <= 4'd0;
        end else begin
            if (!r_emit_valid || emit_done) begin
                if (r_pend_valid) begin
                    r_emit       <= r_pend;
                    r_idx        <= 4'd0;
                    r_emit_valid <= 1'b1;
                    r_pend_valid <= 1'b0;
                end else if (fin_beat) begin
                    r_emit       <= taken_store;
                    r_idx        <= 4'd0;
                    r_emit_valid <= 1'b1;
                end else begin
                    r_emit_valid <= 1'b0;
                end
            end else begin
                if (out_beat) begin
                    for (int k = 0; k < fsnf_pkg::PK_LEN - 1; k++) begin
                        r_emit[k] <= r_emit[k + 1];
                    end
                    r_idx <= r_idx + 4'd1;
                end
                if (fin_beat) begin
                    r_pend       <= taken_store;
                    r_pend_valid <= 1'b1;
                end
            end
        end
    end

    assign o_m_tvalid = r_emit_valid;
    assign o_m_tdata  = {4'b0000, r_idx, r_emit[0]};
    assign o_m_tlast  = (r_idx == fsnf_pkg::IDX_LAST);

endmodule
